[hw/rtl/vfm_pkg.sv]
// Shared types, constants and the mean divider for the vibration frequency monitor.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package vfm_pkg;

  localparam int HISTORY_DEPTH = 5;
  localparam int SLOT_W        = $clog2(HISTORY_DEPTH);
  localparam int SUM_W         = 9 + $clog2(HISTORY_DEPTH);

  // Reciprocal of the depth for the mean: ceil(2^REC_SHIFT / depth).
  localparam int REC_SHIFT = 14;
  localparam int REC_W     = 15;
  localparam logic [REC_W-1:0] RECIP =
    REC_W'((2 ** REC_SHIFT + HISTORY_DEPTH - 1) / HISTORY_DEPTH);

  typedef enum logic [2:0] {
    OP_CAL     = 3'd0,
    OP_ACTIVE  = 3'd1,
    OP_LATCH   = 3'd2,
    OP_PERIOD  = 3'd3,
    OP_RESTART = 3'd4
  } op_t;

  localparam logic [2:0] REG_BAND_LOW    = 3'd0;
  localparam logic [2:0] REG_BAND_HIGH   = 3'd1;
  localparam logic [2:0] REG_TIME_WINDOW = 3'd2;
  localparam logic [2:0] REG_PERIOD      = 3'd3;

  typedef struct packed {
    logic signed [7:0] x;
    logic signed [7:0] y;
    logic signed [7:0] z;
  } sample_t;

  typedef struct packed {
    logic push;   // write sample into history
    logic clear;  // zero the history, keep the slot
  } filt_ctrl_t;

  // Sum / HISTORY_DEPTH, truncated toward zero.
  function automatic logic signed [7:0] mean_div(input logic signed [SUM_W-1:0] sum);
    logic [SUM_W-1:0]       mag;
    logic [SUM_W+REC_W-1:0] prod;
    logic [SUM_W-1:0]       q;
    mag  = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
    prod = {{REC_W{1'b0}}, mag} * {{SUM_W{1'b0}}, RECIP};
    q    = SUM_W'(prod >> REC_SHIFT);
    return sum[SUM_W-1] ? 8'(-q) : 8'(q);
  endfunction

endpackage

`default_nettype wire

[hw/rtl/vibration_frequency_monitor_top.sv]
// Vibration frequency monitor: offset correction, mean filter, Z crossing count,
// period reports and dwell-based warning. Depends on vfm_pkg and vfm_filter.
// Path: input register, then result register; a result stall holds the request
// in the input register.
// Throughput: one request per cycle unless the result stalls; all of a request's
// work is done in the single cycle it leaves the input register.
// Reset: synchronous, active high; clears history, offsets, counters, flags and
// loads the register defaults. No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module vibration_frequency_monitor_top import vfm_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  // configuration write channel
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [13:0]       cfg_data,
  // request channel
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [2:0]        operation,
  input  wire logic signed [7:0] raw_x,
  input  wire logic signed [7:0] raw_y,
  input  wire logic signed [7:0] raw_z,
  // result channel
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic signed [7:0]      filt_x,
  output logic signed [7:0]      filt_y,
  output logic signed [7:0]      filt_z,
  output logic [6:0]             frequency,
  output logic                   warning,
  output logic                   period_report
);

  // ---------------- configuration registers ----------------
  logic [4:0]  band_low;
  logic [4:0]  band_high;
  logic [13:0] time_window_ms;
  logic [13:0] period_ms;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      band_low       <= 5'd2;
      band_high      <= 5'd10;
      time_window_ms <= 14'd3000;
      period_ms      <= 14'd1000;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BAND_LOW:    band_low       <= cfg_data[4:0];
        REG_BAND_HIGH:   band_high      <= cfg_data[4:0];
        REG_TIME_WINDOW: time_window_ms <= cfg_data;
        REG_PERIOD:      period_ms      <= cfg_data;
        default: ;  // unknown index ignored
      endcase
    end
  end

  // ---------------- input register ----------------
  // The request sits here until it is processed, when it moves into the
  // result register, which can happen every cycle unless the result stalls.
  logic    s1_valid;
  op_t     s1_op;
  sample_t s1_raw;
  logic    adv;     // s1 request processed this cycle
  logic    accept;

  assign adv      = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !adv;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else     s1_valid <= accept || (s1_valid && !adv);
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op    <= op_t'(operation);
      s1_raw.x <= raw_x;
      s1_raw.y <= raw_y;
      s1_raw.z <= raw_z;
    end
  end

  // ---------------- processing state ----------------
  logic signed [8:0] offsets [3];      // x, y, z
  sample_t           last_filtered;
  logic [7:0]        crossing_count;
  logic              in_band_flag;
  logic [15:0]       dwell_time;
  logic              warning_flag;

  logic signed [8:0] offsets_next [3];
  sample_t           last_filtered_next;
  logic [7:0]        crossing_count_next;
  logic              in_band_flag_next;
  logic [15:0]       dwell_time_next;
  logic              warning_flag_next;
  logic [6:0]        freq;
  logic              report;

  // filter
  filt_ctrl_t fctrl;
  sample_t    fsample;
  sample_t    fmean;

  vfm_filter u_filter (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (fctrl),
    .sample (fsample),
    .mean   (fmean)
  );

  // Offset-corrected sample, wrapped to 8 bits.
  sample_t           corr;
  logic signed [8:0] sum_x, sum_y, sum_z;
  always_comb begin
    sum_x  = {s1_raw.x[7], s1_raw.x} + offsets[0];
    sum_y  = {s1_raw.y[7], s1_raw.y} + offsets[1];
    sum_z  = {s1_raw.z[7], s1_raw.z} + offsets[2];
    corr.x = sum_x[7:0];
    corr.y = sum_y[7:0];
    corr.z = sum_z[7:0];
  end

  // Deadband: every axis within -1..1.
  function automatic logic near_zero(input logic signed [7:0] v);
    return (v >= -8'sd1) && (v <= 8'sd1);
  endfunction

  logic        near;
  logic        in_band;
  logic [16:0] dwell_sum;
  logic [15:0] dwell_added;   // saturating dwell + period
  logic        window_met;

  always_comb begin
    near        = near_zero(fmean.x) && near_zero(fmean.y) && near_zero(fmean.z);
    dwell_sum   = {1'b0, dwell_time} + {3'b000, period_ms};
    dwell_added = dwell_sum[16] ? 16'hFFFF : dwell_sum[15:0];
    window_met  = dwell_added >= {2'b00, time_window_ms};
    in_band     = (crossing_count[7:1] >= {2'b00, band_low}) &&
                  (crossing_count[7:1] <= {2'b00, band_high});
  end

  always_comb begin
    fctrl               = '0;
    fsample             = (s1_op == OP_ACTIVE) ? corr : s1_raw;
    offsets_next        = offsets;
    last_filtered_next  = last_filtered;
    crossing_count_next = crossing_count;
    in_band_flag_next   = in_band_flag;
    dwell_time_next     = dwell_time;
    warning_flag_next   = warning_flag;
    freq                = '0;
    report              = 1'b0;

    case (s1_op)
      OP_CAL: begin
        fctrl.push         = adv;
        last_filtered_next = fmean;
      end
      OP_ACTIVE: begin
        fctrl.push         = adv;
        last_filtered_next = near ? sample_t'('0) : fmean;
        // sign change of Z against the previous filtered value
        if ((last_filtered_next.z[7] != last_filtered.z[7]) &&
            (crossing_count != 8'hFF))
          crossing_count_next = crossing_count + 8'd1;
      end
      OP_LATCH: begin
        fctrl.clear     = adv;
        offsets_next[0] = -{last_filtered.x[7], last_filtered.x};
        offsets_next[1] = -{last_filtered.y[7], last_filtered.y};
        offsets_next[2] = -{last_filtered.z[7], last_filtered.z};
      end
      OP_PERIOD: begin
        freq   = crossing_count[7:1];
        report = 1'b1;
        if (in_band == in_band_flag) begin
          // staying on the same side: accumulate dwell, maybe switch warning
          dwell_time_next = dwell_added;
          if (window_met) warning_flag_next = in_band;
        end else begin
          dwell_time_next   = {2'b00, period_ms};
          in_band_flag_next = in_band;
        end
        crossing_count_next = '0;
      end
      OP_RESTART: begin
        crossing_count_next = '0;
        in_band_flag_next   = 1'b0;
        dwell_time_next     = '0;
        warning_flag_next   = 1'b0;
      end
      default: ;  // unused codes: plain result, no state change
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < 3; a++) offsets[a] <= '0;
      last_filtered  <= '0;
      crossing_count <= '0;
      in_band_flag   <= 1'b0;
      dwell_time     <= '0;
      warning_flag   <= 1'b0;
    end else if (adv) begin
      offsets        <= offsets_next;
      last_filtered  <= last_filtered_next;
      crossing_count <= crossing_count_next;
      in_band_flag   <= in_band_flag_next;
      dwell_time     <= dwell_time_next;
      warning_flag   <= warning_flag_next;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst)      out_valid <= 1'b0;
    else if (adv) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      filt_x        <= last_filtered_next.x;
      filt_y        <= last_filtered_next.y;
      filt_z        <= last_filtered_next.z;
      frequency     <= freq;
      warning       <= warning_flag_next;
      period_report <= report;
    end
  end

  // ---------------- assertions ----------------
  a_freq_only_on_report: assert property (@(posedge clk) disable iff (rst)
    out_valid && !period_report |-> frequency == 7'd0)
    else $error("frequency nonzero on a non-report result");

  a_restart_clears_warning: assert property (@(posedge clk) disable iff (rst)
    adv && s1_op == OP_RESTART |=> !warning_flag && dwell_time == 16'd0)
    else $error("restart did not clear warning state");

  a_period_clears_count: assert property (@(posedge clk) disable iff (rst)
    adv && s1_op == OP_PERIOD |=> crossing_count == 8'd0)
    else $error("period end did not clear crossing count");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid && out_stall)
    else $error("input stalled without a blocked result");

endmodule

`default_nettype wire

[hw/rtl/vfm_filter.sv]
// Sample history and moving-average mean over HISTORY_DEPTH samples.
// Depends on vfm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vfm_filter import vfm_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire filt_ctrl_t ctrl,
  input  wire sample_t    sample,
  output sample_t         mean
);

  sample_t           history [HISTORY_DEPTH];
  logic [SLOT_W-1:0] write_slot;
  logic [SLOT_W-1:0] slot_eff;
  logic [SLOT_W-1:0] write_slot_next;
  sample_t           hist_next [HISTORY_DEPTH];
  logic signed [SUM_W-1:0] sum_x, sum_y, sum_z;

  always_comb begin
    slot_eff = (int'(write_slot) >= HISTORY_DEPTH) ? '0 : write_slot;
    write_slot_next = (int'(slot_eff) == HISTORY_DEPTH - 1) ? '0 : slot_eff + 1'b1;
  end

  // History with the new sample in place; the mean is taken over this.
  always_comb begin
    sum_x = '0;
    sum_y = '0;
    sum_z = '0;
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      hist_next[i] = (i == int'(slot_eff)) ? sample : history[i];
      sum_x = sum_x + {{(SUM_W-8){hist_next[i].x[7]}}, hist_next[i].x};
      sum_y = sum_y + {{(SUM_W-8){hist_next[i].y[7]}}, hist_next[i].y};
      sum_z = sum_z + {{(SUM_W-8){hist_next[i].z[7]}}, hist_next[i].z};
    end
    mean.x = mean_div(sum_x);
    mean.y = mean_div(sum_y);
    mean.z = mean_div(sum_z);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot <= '0;
      for (int i = 0; i < HISTORY_DEPTH; i++) history[i] <= '0;
    end else if (ctrl.clear) begin
      for (int i = 0; i < HISTORY_DEPTH; i++) history[i] <= '0;
    end else if (ctrl.push) begin
      for (int i = 0; i < HISTORY_DEPTH; i++) history[i] <= hist_next[i];
      write_slot <= write_slot_next;
    end
  end

endmodule

`default_nettype wire

[verif/testbench.sv]
`timescale 1ns / 1ps
// Self-checking bench for vibration_frequency_monitor_top: directed and random requests,
// register sweeps, idling and hold-off on both channels, checked by an in-bench predictor.
// Depends on vfm_pkg and the monitor RTL.

module testbench;
  import vfm_pkg::*;

  // Cycles with no handshake of any kind before the run is declared hung. The longest
  // legal quiet stretch is the output hold-off plus a few random stalls.
  localparam int WATCHDOG_LIMIT = 2000;
  // Two-stage pipeline; wait a few times that after the last result.
  localparam int SETTLE_CYCLES  = 10;
  localparam int HOLD_OFF_LEN   = 150;

  typedef struct {
    logic signed [7:0] fx;
    logic signed [7:0] fy;
    logic signed [7:0] fz;
    logic [6:0]        freq;
    logic              warn;
    logic              report;
  } monitor_result_t;

  // DUT ports, all inputs known from time zero
  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [2:0]        cfg_index = '0;
  logic [13:0]       cfg_data  = '0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  logic [2:0]        operation = '0;
  logic signed [7:0] raw_x     = '0;
  logic signed [7:0] raw_y     = '0;
  logic signed [7:0] raw_z     = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic signed [7:0] filt_x;
  logic signed [7:0] filt_y;
  logic signed [7:0] filt_z;
  logic [6:0]        frequency;
  logic              warning;
  logic              period_report;

  vibration_frequency_monitor_top dut (.*);

  initial forever #5 clk = ~clk;

  // Bench-side copy of the monitor: registers (reset defaults) and filter/warning state.
  int band_low_q  = 2;
  int band_high_q = 10;
  int window_ms_q = 3000;
  int period_ms_q = 1000;
  int hist [HISTORY_DEPTH][3];
  int hist_slot;
  int cal_offset [3];
  int mean_now [3];
  int z_crossings;
  bit in_band;
  int dwell_ms;
  bit warn_on;

  monitor_result_t expected_results[$];

  // Traffic shaping knobs: idle and stall chances in percent per cycle, and a hold-off length
  int send_idle_pct;
  int stall_pct;
  int hold_off_cycles;

  int requests_sent;
  int results_checked;
  int register_writes;
  int mismatches;
  int quiet_cycles;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Two's complement wrap of a sum back to one 8-bit reading
  function automatic int wrap8(int v);
    logic signed [7:0] w;
    w = v[7:0];
    return int'(w);
  endfunction

  // Write one sample into the ring and recompute the truncating mean of every axis
  function automatic void push_sample(int sx, int sy, int sz);
    int total;
    hist[hist_slot][0] = sx;
    hist[hist_slot][1] = sy;
    hist[hist_slot][2] = sz;
    hist_slot = (hist_slot + 1) % HISTORY_DEPTH;
    for (int a = 0; a < 3; a++) begin
      total = 0;
      for (int i = 0; i < HISTORY_DEPTH; i++) total += hist[i][a];
      mean_now[a] = total / HISTORY_DEPTH;  // int division truncates toward zero
    end
  endfunction

  function automatic monitor_result_t predict_monitor_result(logic [2:0] op,
      logic signed [7:0] x, logic signed [7:0] y, logic signed [7:0] z);
    monitor_result_t r;
    int z_before;
    int halved;
    bit near_zero;
    bit in_range;
    halved   = 0;
    r.report = 1'b0;
    case (op)
      OP_CAL: begin
        // calibration: raw readings, no offsets, no deadband, no crossing count
        push_sample(x, y, z);
      end
      OP_ACTIVE: begin
        z_before = mean_now[2];
        push_sample(wrap8(x + cal_offset[0]), wrap8(y + cal_offset[1]),
                    wrap8(z + cal_offset[2]));
        near_zero = 1'b1;
        for (int a = 0; a < 3; a++)
          if (mean_now[a] < -1 || mean_now[a] > 1) near_zero = 1'b0;
        if (near_zero) mean_now = '{0, 0, 0};
        if (((mean_now[2] < 0) != (z_before < 0)) && z_crossings < 255) z_crossings++;
      end
      OP_LATCH: begin
        for (int a = 0; a < 3; a++) cal_offset[a] = -mean_now[a];
        foreach (hist[i, a]) hist[i][a] = 0;
      end
      OP_PERIOD: begin
        halved   = z_crossings / 2;
        r.report = 1'b1;
        in_range = (halved >= band_low_q) && (halved <= band_high_q);
        if (in_range == in_band) begin
          // same side of the band as last time: accumulate dwell, then decide
          dwell_ms = (dwell_ms + period_ms_q > 65535) ? 65535 : dwell_ms + period_ms_q;
          if (dwell_ms >= window_ms_q) warn_on = in_range;
        end else begin
          dwell_ms = period_ms_q;
          in_band  = in_range;
        end
        z_crossings = 0;
      end
      OP_RESTART: begin
        z_crossings = 0;
        in_band     = 1'b0;
        dwell_ms    = 0;
        warn_on     = 1'b0;
      end
      default: ;  // unused codes only answer
    endcase
    r.fx   = mean_now[0][7:0];
    r.fy   = mean_now[1][7:0];
    r.fz   = mean_now[2][7:0];
    r.freq = halved[6:0];
    r.warn = warn_on;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking, receiver stalls and watchdog
  // ---------------------------------------------------------------------------

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : result_checker
    monitor_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with nothing expected, actual fz %0d freq %0d", $time,
                 filt_z, frequency);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("filt_x", want.fx, filt_x);
        check_field("filt_y", want.fy, filt_y);
        check_field("filt_z", want.fz, filt_z);
        check_field("frequency", want.freq, frequency);
        check_field("warning", want.warn, warning);
        check_field("period_report", want.report, period_report);
        results_checked++;
      end
    end
  end

  // Receiver: either a counted hold-off or random per-cycle stalls
  always @(posedge clk) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d results outstanding", $time,
               quiet_cycles, expected_results.size());
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Valid is left high after acceptance; the next call either lowers it for a gap
  // or keeps it up, so each step sees a single assignment to it.
  task automatic send_request(logic [2:0] op, logic signed [7:0] x, logic signed [7:0] y,
                              logic signed [7:0] z);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    raw_x     <= x;
    raw_y     <= y;
    raw_z     <= z;
    do @(posedge clk); while (in_stall);
    expected_results.push_back(predict_monitor_result(op, x, y, z));
    requests_sent++;
  endtask

  // Sender pause: stop offering and wait for every outstanding result
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  // Only called with the block idle
  task automatic write_register(logic [2:0] idx, logic [13:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_BAND_LOW:    band_low_q  = data[4:0];
      REG_BAND_HIGH:   band_high_q = data[4:0];
      REG_TIME_WINDOW: window_ms_q = data;
      REG_PERIOD:      period_ms_q = data;
      default: ;  // unknown index, ignored
    endcase
    register_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_config(int lo, int hi, int window_ms, int period_ms);
    write_register(REG_BAND_LOW, 14'(lo));
    write_register(REG_BAND_HIGH, 14'(hi));
    write_register(REG_TIME_WINDOW, 14'(window_ms));
    write_register(REG_PERIOD, 14'(period_ms));
  endtask

  function automatic logic [13:0] random_register_value(logic [2:0] idx);
    case (idx)
      REG_BAND_LOW:    return 14'($urandom_range(0, 8));
      REG_BAND_HIGH:   return 14'($urandom_range(4, 25));
      REG_TIME_WINDOW: return 14'($urandom_range(0, 4) * 2500);
      REG_PERIOD:      return 14'($urandom_range(500, 10000));
      default:         return 14'($urandom);
    endcase
  endfunction

  // Half full-scale, half near zero so the deadband gets hit
  function automatic logic signed [7:0] random_axis();
    if ($urandom_range(1)) return 8'($urandom);
    return 8'(int'($urandom_range(4)) - 2);
  endfunction

  // One reporting period: a square-ish Z wave of the given half length, then period end
  task automatic run_period(int halves, int half_len, int amp);
    int sign = 1;
    for (int h = 0; h < halves; h++) begin
      for (int k = 0; k < half_len; k++)
        send_request(OP_ACTIVE, random_axis(), random_axis(),
                     8'(sign * amp + int'($urandom_range(10)) - 5));
      sign = -sign;
    end
    send_request(OP_PERIOD, random_axis(), random_axis(), random_axis());
  endtask

  // Sensor at rest around some bias, usually followed by a latch
  task automatic run_calibration();
    logic signed [7:0] bx;
    logic signed [7:0] by;
    logic signed [7:0] bz;
    bx = random_axis();
    by = random_axis();
    bz = random_axis();
    repeat ($urandom_range(1, 8))
      send_request(OP_CAL, 8'(bx + int'($urandom_range(6)) - 3),
                   8'(by + int'($urandom_range(6)) - 3), 8'(bz + int'($urandom_range(6)) - 3));
    if ($urandom_range(3) != 0) send_request(OP_LATCH, random_axis(), random_axis(),
                                             random_axis());
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_operations_directed();
    // full-scale readings, then a calibration sample and a latch; the means cancel so offsets stay zero
    send_request(OP_ACTIVE, 127, 127, 127);
    send_request(OP_ACTIVE, -128, -128, -128);
    send_request(OP_ACTIVE, 127, -128, 0);
    send_request(OP_CAL, -128, 127, -1);
    send_request(OP_LATCH, 0, 0, 0);
    send_request(OP_ACTIVE, 127, 127, 127);
    send_request(OP_PERIOD, 0, 0, 0);
    // flush the filter with zero calibration samples; latch gives zero offsets
    repeat (HISTORY_DEPTH) send_request(OP_CAL, 0, 0, 0);
    send_request(OP_LATCH, 0, 0, 0);
    // the first two small readings land inside the deadband and read back as zero; the third moves Z out
    send_request(OP_ACTIVE, 3, -4, 2);
    send_request(OP_ACTIVE, 5, 5, -5);
    send_request(OP_ACTIVE, 0, 0, -10);
    send_request(OP_RESTART, 0, 0, 0);
    for (int op = OP_RESTART + 1; op < 8; op++) send_request(3'(op), -1, 1, -1);
  endtask

  // Alternating full-scale Z flips the mean every sample: 300 flips saturate the count
  task automatic test_crossing_saturation();
    repeat (HISTORY_DEPTH) send_request(OP_CAL, 0, 0, 0);
    send_request(OP_LATCH, 0, 0, 0);
    run_period(300, 1, 120);
  endtask

  task automatic test_register_sweep();
    wait_for_results();
    // widest band and no dwell: warning comes up on the second in-band report
    load_config(0, 25, 0, 500);
    send_request(OP_RESTART, 0, 0, 0);
    repeat (3) run_period($urandom_range(4, 20), 2, 100);
    wait_for_results();
    // empty band, longest period and window: dwell saturates while out of band
    load_config(20, 3, 10000, 10000);
    repeat (8) send_request(OP_PERIOD, random_axis(), random_axis(), random_axis());
    wait_for_results();
    for (int idx = 4; idx < 8; idx++) write_register(3'(idx), 14'($urandom));
    // band of zero only: empty periods count as in band
    load_config(0, 0, 500, 500);
    repeat (4) send_request(OP_PERIOD, 0, 0, 0);
    wait_for_results();
    // single-value band at the top of the range
    load_config(25, 25, 10000, 500);
    repeat (2) run_period(52, 1, 110);
    wait_for_results();
    load_config(2, 10, 3000, 1000);
  endtask

  // Output held off long enough that the pipeline fills and the input stalls
  task automatic test_output_holdoff();
    send_idle_pct   = 0;
    stall_pct       = 0;
    hold_off_cycles = HOLD_OFF_LEN;
    repeat (30) send_request(OP_ACTIVE, random_axis(), random_axis(), random_axis());
    wait_for_results();
    send_request(OP_PERIOD, 0, 0, 0);
  endtask

  // Mostly whole periods in runs that stay in or out of band, so the dwell logic
  // gets to switch the warning; the rest is calibration, restarts, register writes and noise.
  task automatic test_random_traffic(int sender_idle, int receiver_stall, int n_requests);
    int stop_at;
    int pick;
    int regime_left;
    int halves;
    bit regime_in;
    logic [2:0] idx;
    wait_for_results();
    send_idle_pct = sender_idle;
    stall_pct     = receiver_stall;
    for (int r = 0; r < 4; r++) write_register(3'(r), random_register_value(3'(r)));
    stop_at     = requests_sent + n_requests;
    regime_left = 0;
    while (requests_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        if (regime_left == 0) begin
          regime_left = $urandom_range(1, 8);
          regime_in   = $urandom_range(1);
        end
        regime_left--;
        if (regime_in) halves = $urandom_range(4, 22);
        else halves = $urandom_range(1) ? $urandom_range(0, 3) : $urandom_range(24, 60);
        run_period(halves, (halves > 20) ? $urandom_range(1, 2) : $urandom_range(1, 6),
                   $urandom_range(0, 120));
      end else if (pick < 75) begin
        run_calibration();
      end else if (pick < 80) begin
        send_request(OP_RESTART, random_axis(), random_axis(), random_axis());
      end else if (pick < 84) begin
        wait_for_results();
        idx = 3'($urandom_range(7));
        write_register(idx, random_register_value(idx));
      end else begin
        send_request(3'($urandom), random_axis(), random_axis(), random_axis());
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_operations_directed();
    test_crossing_saturation();
    test_register_sweep();
    test_output_holdoff();
    test_random_traffic(0, 0, 200);
    test_random_traffic(62, 0, 200);
    test_random_traffic(0, 62, 200);
    test_random_traffic(31, 31, 200);

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Run: %0d requests, %0d results checked, %0d register writes,", requests_sent,
             results_checked, register_writes);
    $display("  band/window sweeps, count saturation, output hold-off and four idle mixes.");
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches, %0d results never arrived", mismatches,
               expected_results.size());
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
